@@ hdl/longest_prefix_route_table_defines.svh @@
// Assertion macros for the longest-prefix route table checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH
`define LONGEST_PREFIX_ROUTE_TABLE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LPRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define LPRT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

@@ hdl/lprt_pkg.sv @@
// Shared types, codes and helpers for the longest-prefix route table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lprt_pkg;

    localparam int unsigned ROUTE_ENTRIES_DEF = 16;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned IFC_W   = 8;
    localparam int unsigned BITS_W  = 6;   // holds a population count of 0..32
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned STAT_W  = 2;

    // Stream widths: fields packed from bit 0, padded to whole bytes.
    localparam int unsigned IN_DATA_W  = 168;
    localparam int unsigned IN_USER_W  = 8;
    localparam int unsigned OUT_DATA_W = 136;
    localparam int unsigned OUT_USER_W = 8;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_HOST_BITS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STAT_W-1:0] ST_NO_ROUTE  = 2'd3;

    // Route fields as carried through the chain and to the output.
    typedef struct packed {
        logic [ADDR_W-1:0] net;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gw;
        logic [ADDR_W-1:0] metric;
        logic [IFC_W-1:0]  ifc;
    } t_route;

    // Token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic              active;
        logic [KIND_W-1:0] kind;
        logic              host_err;
        logic              placed;
        logic              found;
        t_route            route;      // route of an add item
        logic [BITS_W-1:0] bits;       // mask bit count of an add item
        logic [ADDR_W-1:0] dst;
        logic [BITS_W-1:0] win_bits;
        t_route            best;
    } t_token;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        t_route            route;
    } t_result;

    function automatic logic [BITS_W-1:0] ones_count(input logic [ADDR_W-1:0] v);
        logic [BITS_W-1:0] n;
        n = '0;
        for (int b = 0; b < ADDR_W; b++) begin
            n = n + BITS_W'(v[b]);
        end
        return n;
    endfunction

endpackage

@@ hdl/lprt_cell.sv @@
// One route slot of the chain: holds an entry and updates the passing token.
// Depends on lprt_pkg.
`timescale 1ns / 1ps

module lprt_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lprt_pkg::t_token i_tok,
    output lprt_pkg::t_token o_tok
);
    import lprt_pkg::*;

    logic              r_valid;
    logic              n_valid;
    t_route            r_entry;
    logic [BITS_W-1:0] r_bits;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_write;
    logic              w_match;
    logic              w_better;

    assign w_match  = r_valid && ((i_tok.dst & r_entry.mask) == r_entry.net);
    assign w_better = !i_tok.found || (r_bits > i_tok.win_bits) ||
                      ((r_bits == i_tok.win_bits) && (r_entry.metric < i_tok.best.metric));

    always_comb begin
        n_tok   = i_tok;
        n_valid = r_valid;
        w_write = 1'b0;
        if (i_tok.active) begin
            unique case (i_tok.kind)
                KIND_ADD: begin
                    if (!i_tok.host_err && !i_tok.placed && !r_valid) begin
                        w_write      = 1'b1;
                        n_valid      = 1'b1;
                        n_tok.placed = 1'b1;
                    end
                end
                KIND_LOOKUP: begin
                    if (w_match && w_better) begin
                        n_tok.found    = 1'b1;
                        n_tok.win_bits = r_bits;
                        n_tok.best     = r_entry;
                    end
                end
                KIND_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                    // unused kind: pass through untouched
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_tok.active <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_tok   <= n_tok;
        end
    end

    // entry payload: written only by an add, no reset
    always_ff @(posedge i_clk) begin
        if (w_write) begin
            r_entry <= i_tok.route;
            r_bits  <= i_tok.bits;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ hdl/longest_prefix_route_table.sv @@
// Channel   Dir  tdata (low bit up)                          tuser
// s_axis    in   network, netmask, gateway, metric,          kind [1:0]
//                interface_number, destination (168 bits)
// m_axis    out  route_network, route_mask, route_gateway,   status [1:0]
//                route_metric, route_interface (136 bits)
//
// An item's token walks the row of slot cells, one cell per cycle, and its
// result is then registered in the output stage. One item is in the chain at
// a time; the next is taken only once the result has left the last cell and
// the skid register is empty, so no item is taken before the last is through.
// A result held by m_axis_tready low lets one more land in a skid register;
// s_axis stalls while the skid is full.
// Reset (i_rst_n low, synchronous) invalidates every slot at once.
// Top level of the longest-prefix route table; depends on lprt_pkg, lprt_cell.
`timescale 1ns / 1ps

module longest_prefix_route_table #(
    parameter int unsigned ROUTE_ENTRIES = lprt_pkg::ROUTE_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // network[31:0], netmask[63:32], gateway[95:64], metric[127:96],
    // interface_number[135:128], destination[167:136]
    input  logic [lprt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind[1:0], zero fill above
    input  logic [lprt_pkg::IN_USER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // route_network[31:0], route_mask[63:32], route_gateway[95:64],
    // route_metric[127:96], route_interface[135:128]
    output logic [lprt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // status[1:0], zero fill above
    output logic [lprt_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import lprt_pkg::*;

    t_token  w_tok [ROUTE_ENTRIES+1];
    t_token  w_launch;
    t_token  w_done;
    t_result w_res;

    logic    w_in_acc;
    logic    w_out_acc;
    logic    w_finish;

    logic    r_busy;
    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;

    assign s_axis_tready = !r_busy && !r_skid_valid;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_acc     = m_axis_tvalid && m_axis_tready;

    // Build the token for a freshly accepted item; flag host bits up front.
    always_comb begin
        w_launch            = '0;
        w_launch.active     = w_in_acc;
        w_launch.kind       = s_axis_tuser[KIND_W-1:0];
        w_launch.route.net  = s_axis_tdata[31:0];
        w_launch.route.mask = s_axis_tdata[63:32];
        w_launch.route.gw   = s_axis_tdata[95:64];
        w_launch.route.metric = s_axis_tdata[127:96];
        w_launch.route.ifc  = s_axis_tdata[135:128];
        w_launch.dst        = s_axis_tdata[167:136];
        w_launch.bits       = ones_count(s_axis_tdata[63:32]);
        w_launch.host_err   = (w_launch.kind == KIND_ADD) &&
                              ((s_axis_tdata[31:0] & ~s_axis_tdata[63:32]) != '0);
    end

    assign w_tok[0] = w_launch;

    for (genvar g = 0; g < ROUTE_ENTRIES; g++) begin : g_cell
        lprt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_done   = w_tok[ROUTE_ENTRIES];
    assign w_finish = w_done.active;

    // Turn the token leaving the last cell into a result item.
    always_comb begin
        w_res        = '0;
        w_res.status = ST_OK;
        if (w_done.host_err) begin
            w_res.status = ST_HOST_BITS;
        end else if (w_done.kind == KIND_ADD && !w_done.placed) begin
            w_res.status = ST_FULL;
        end else if (w_done.kind == KIND_LOOKUP) begin
            if (w_done.found) begin
                w_res.route = w_done.best;
            end else begin
                w_res.status = ST_NO_ROUTE;
            end
        end
    end

    // Control: busy while a token is in the chain, output and skid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_busy <= 1'b1;
            end else if (w_finish) begin
                r_busy <= 1'b0;
            end
            if (w_out_acc) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else if (!w_finish) begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_finish) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // Payload: advance skid into output, or load the new result.
    always_ff @(posedge i_clk) begin
        if (w_out_acc) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (w_finish) begin
                r_out <= w_res;
            end
        end else if (w_finish) begin
            if (r_out_valid) begin
                r_skid <= w_res;
            end else begin
                r_out <= w_res;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.route.ifc, r_out.route.metric, r_out.route.gw,
                            r_out.route.mask, r_out.route.net};
    assign m_axis_tuser  = {(OUT_USER_W-STAT_W)'(0), r_out.status};

endmodule

@@ hdl/lprt_checker.sv @@
// Port-level checks for the longest-prefix route table, bound to the top.
// Depends on lprt_pkg and longest_prefix_route_table_defines.svh.
`timescale 1ns / 1ps
`include "longest_prefix_route_table_defines.svh"

module lprt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [lprt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic [lprt_pkg::OUT_USER_W-1:0]    m_axis_tuser
);
    import lprt_pkg::*;

    logic w_fail;

    assign w_fail = m_axis_tvalid && (m_axis_tuser[STAT_W-1:0] != ST_OK);

    // a waiting result stays offered
    `LPRT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
    // an accepted item occupies the chain, so the next cycle takes no item
    `LPRT_ASSERT(a_one_item, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "chain overrun")
    // any failing status carries an all-zero route
    `LPRT_ASSERT(a_fail_zero, w_fail |-> m_axis_tdata == '0, "route fields set on failure")
    // reset empties the output stage
    `LPRT_ASSERT_RST(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "result offered after reset")

endmodule

bind longest_prefix_route_table lprt_checker u_lprt_checker (.*);
